// ===== sv/sle_pkg.sv =====
package sle_pkg;

    // operation kinds carried by one input beat
    typedef logic [2:0] t_kind;
    localparam t_kind K_INSERT = 3'd0;
    localparam t_kind K_DELETE = 3'd1;
    localparam t_kind K_FIND   = 3'd2;
    localparam t_kind K_READ   = 3'd3;
    localparam t_kind K_DELMIN = 3'd4;

    // what to do with store read data when it returns, in the cycle after the read
    typedef logic [2:0] t_tag;
    localparam t_tag TG_NONE  = 3'd0;
    localparam t_tag TG_UP    = 3'd1;
    localparam t_tag TG_DOWN  = 3'd2;
    localparam t_tag TG_FIND  = 3'd3;
    localparam t_tag TG_MIN   = 3'd4;
    localparam t_tag TG_ELEM  = 3'd5;
    localparam t_tag TG_TOMIN = 3'd6;

    // index and remaining-count preload selects
    typedef logic [2:0] t_ld;
    localparam t_ld LD_NONE = 3'd0;
    localparam t_ld LD_INS  = 3'd1;
    localparam t_ld LD_POS  = 3'd2;
    localparam t_ld LD_SCAN = 3'd3;
    localparam t_ld LD_LAST = 3'd4;

    typedef logic [1:0] t_idx_op;
    localparam t_idx_op IDX_HOLD = 2'd0;
    localparam t_idx_op IDX_INC  = 2'd1;
    localparam t_idx_op IDX_DEC  = 2'd2;

    typedef logic [1:0] t_cnt_op;
    localparam t_cnt_op CNT_HOLD = 2'd0;
    localparam t_cnt_op CNT_INC  = 2'd1;
    localparam t_cnt_op CNT_DEC  = 2'd2;

    typedef logic [1:0] t_cond;
    localparam t_cond CND_NEVER = 2'd0;
    localparam t_cond CND_BAD   = 2'd1;
    localparam t_cond CND_REM_Z = 2'd2;

    typedef logic [4:0] t_upc;

    // microprogram step addresses
    localparam t_upc S_INS_CHK  = 5'd0;
    localparam t_upc S_INS_LOOP = 5'd1;
    localparam t_upc S_INS_DRN  = 5'd2;
    localparam t_upc S_INS_END  = 5'd3;
    localparam t_upc S_DEL_CHK  = 5'd4;
    localparam t_upc S_DEL_RD   = 5'd5;
    localparam t_upc S_DEL_LOOP = 5'd6;
    localparam t_upc S_DEL_END  = 5'd7;
    localparam t_upc S_FND_LD   = 5'd8;
    localparam t_upc S_FND_LOOP = 5'd9;
    localparam t_upc S_FND_END  = 5'd10;
    localparam t_upc S_RD_CHK   = 5'd11;
    localparam t_upc S_RD_RD    = 5'd12;
    localparam t_upc S_RD_END   = 5'd13;
    localparam t_upc S_MIN_CHK  = 5'd14;
    localparam t_upc S_MIN_LOOP = 5'd15;
    localparam t_upc S_MIN_LAST = 5'd16;
    localparam t_upc S_MIN_MOVE = 5'd17;
    localparam t_upc S_MIN_END  = 5'd18;
    localparam t_upc S_FAIL     = 5'd19;

    // one control word
    typedef struct packed {
        logic    rd_en;
        t_tag    tag;
        t_idx_op idx_op;
        logic    rem_dec;
        t_ld     ld;
        logic    wr_val;
        t_cnt_op cnt_op;
        logic    set_ok;
        logic    min_elem;
        logic    done;
        t_cond   cond;
        logic    hold;
        t_upc    target;
    } t_ctrl;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic bad;
        logic rem_z;
    } t_stat;

    // control store
    function automatic t_ctrl rom(input t_upc upc);
        t_ctrl c;
        c = '0;
        case (upc)
            S_INS_CHK: begin
                c.ld = LD_INS; c.cond = CND_BAD; c.target = S_FAIL;
            end
            S_INS_LOOP: begin
                c.rd_en = 1'b1; c.tag = TG_UP; c.idx_op = IDX_DEC; c.rem_dec = 1'b1;
                c.cond = CND_REM_Z; c.hold = 1'b1; c.target = S_INS_DRN;
            end
            S_INS_DRN: begin
                c.cond = CND_NEVER;
            end
            S_INS_END: begin
                c.wr_val = 1'b1; c.cnt_op = CNT_INC; c.set_ok = 1'b1; c.done = 1'b1;
            end
            S_DEL_CHK: begin
                c.ld = LD_POS; c.cond = CND_BAD; c.target = S_FAIL;
            end
            S_DEL_RD: begin
                c.rd_en = 1'b1; c.tag = TG_ELEM; c.idx_op = IDX_INC;
            end
            S_DEL_LOOP: begin
                c.rd_en = 1'b1; c.tag = TG_DOWN; c.idx_op = IDX_INC; c.rem_dec = 1'b1;
                c.cond = CND_REM_Z; c.hold = 1'b1; c.target = S_DEL_END;
            end
            S_DEL_END: begin
                c.cnt_op = CNT_DEC; c.set_ok = 1'b1; c.done = 1'b1;
            end
            S_FND_LD: begin
                c.ld = LD_SCAN;
            end
            S_FND_LOOP: begin
                c.rd_en = 1'b1; c.tag = TG_FIND; c.idx_op = IDX_INC; c.rem_dec = 1'b1;
                c.cond = CND_REM_Z; c.hold = 1'b1; c.target = S_FND_END;
            end
            S_FND_END: begin
                c.done = 1'b1;
            end
            S_RD_CHK: begin
                c.ld = LD_POS; c.cond = CND_BAD; c.target = S_FAIL;
            end
            S_RD_RD: begin
                c.rd_en = 1'b1; c.tag = TG_ELEM;
            end
            S_RD_END: begin
                c.set_ok = 1'b1; c.done = 1'b1;
            end
            S_MIN_CHK: begin
                c.ld = LD_SCAN; c.cond = CND_BAD; c.target = S_FAIL;
            end
            S_MIN_LOOP: begin
                c.rd_en = 1'b1; c.tag = TG_MIN; c.idx_op = IDX_INC; c.rem_dec = 1'b1;
                c.cond = CND_REM_Z; c.hold = 1'b1; c.target = S_MIN_LAST;
            end
            S_MIN_LAST: begin
                c.ld = LD_LAST;
            end
            S_MIN_MOVE: begin
                c.rd_en = 1'b1; c.tag = TG_TOMIN;
            end
            S_MIN_END: begin
                c.min_elem = 1'b1; c.cnt_op = CNT_DEC; c.set_ok = 1'b1; c.done = 1'b1;
            end
            S_FAIL: begin
                c.done = 1'b1;
            end
            default: begin
                c.done = 1'b1;
            end
        endcase
        return c;
    endfunction

    // first step of each operation
    function automatic t_upc entry(input t_kind kind);
        t_upc a;
        case (kind)
            K_INSERT: a = S_INS_CHK;
            K_DELETE: a = S_DEL_CHK;
            K_FIND:   a = S_FND_LD;
            K_READ:   a = S_RD_CHK;
            K_DELMIN: a = S_MIN_CHK;
            default:  a = S_FAIL;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/sle_ram.sv =====
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic [WIDTH-1:0]         i_wd,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_ra,
    output logic [WIDTH-1:0]         o_rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            o_rd <= mem[i_ra];
        end
    end

endmodule

// ===== sv/sle_dp.sv =====
module sle_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0]          i_kind,
    input  logic [4:0]          i_position,
    input  logic signed [31:0]  i_value,
    input  sle_pkg::t_ctrl      i_ctl,
    output sle_pkg::t_stat      o_stat,
    output logic                o_strobe,
    output logic                o_ok,
    output logic signed [31:0]  o_element,
    output logic [4:0]          o_found_at,
    output logic [4:0]          o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 5) ? CW : 5) + 1;

    logic [2:0]           r_kind;
    logic [4:0]           r_pos;
    logic [31:0]          r_val;
    logic [CW-1:0]        r_cnt,   n_cnt;
    logic [AW-1:0]        r_idx,   n_idx;
    logic [CW-1:0]        r_rem,   n_rem;
    logic                 r_ok,    n_ok;
    logic [31:0]          r_elem,  n_elem;
    logic [4:0]           r_at,    n_at;
    logic [31:0]          r_min,   n_min;
    logic [AW-1:0]        r_midx,  n_midx;
    sle_pkg::t_tag        r_fl_tag;
    logic [AW-1:0]        r_fl_addr;
    logic                 r_strobe;

    logic [PW-1:0]        w_p;
    logic [PW-1:0]        w_n;
    logic [AW-1:0]        w_pm1;
    logic [AW-1:0]        w_nm1;
    logic [AW:0]          w_at_full;
    logic                 w_ins_ok;
    logic                 w_pos_ok;
    logic                 w_we;
    logic [AW-1:0]        w_wa;
    logic [31:0]          w_wd;
    logic [31:0]          w_rd;

    // operands in a common width
    assign w_p       = PW'(r_pos);
    assign w_n       = PW'(r_cnt);
    assign w_pm1     = AW'(w_p - PW'(1));
    assign w_nm1     = AW'(w_n - PW'(1));
    assign w_at_full = {1'b0, r_fl_addr} + (AW+1)'(1);
    assign w_ins_ok  = (w_p != '0) && (w_p <= w_n + PW'(1)) && (w_n < PW'(CAPACITY));
    assign w_pos_ok  = (w_p != '0) && (w_p <= w_n);

    // status for conditional jumps
    always_comb begin
        o_stat.rem_z = (r_rem == '0);
        case (r_kind)
            sle_pkg::K_INSERT: o_stat.bad = !w_ins_ok;
            sle_pkg::K_DELETE: o_stat.bad = !w_pos_ok;
            sle_pkg::K_READ:   o_stat.bad = !w_pos_ok;
            sle_pkg::K_DELMIN: o_stat.bad = (r_cnt == '0);
            default:           o_stat.bad = 1'b0;
        endcase
    end

    // store write port: returning read data, or the inserted value
    always_comb begin
        w_we = 1'b0;
        w_wa = r_fl_addr;
        w_wd = w_rd;
        case (r_fl_tag)
            sle_pkg::TG_UP: begin
                w_we = 1'b1;
                w_wa = r_fl_addr + AW'(1);
            end
            sle_pkg::TG_DOWN: begin
                w_we = 1'b1;
                w_wa = r_fl_addr - AW'(1);
            end
            sle_pkg::TG_TOMIN: begin
                w_we = 1'b1;
                w_wa = r_midx;
            end
            default: begin
                if (i_ctl.wr_val) begin
                    w_we = 1'b1;
                    w_wa = w_pm1;
                    w_wd = r_val;
                end
            end
        endcase
    end

    sle_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk (i_clk),
        .i_we  (w_we),
        .i_wa  (w_wa),
        .i_wd  (w_wd),
        .i_re  (i_ctl.rd_en),
        .i_ra  (r_idx),
        .o_rd  (w_rd)
    );

    // next values of the working registers
    always_comb begin
        n_cnt  = r_cnt;
        n_idx  = r_idx;
        n_rem  = r_rem;
        n_ok   = r_ok;
        n_elem = r_elem;
        n_at   = r_at;
        n_min  = r_min;
        n_midx = r_midx;

        case (i_ctl.ld)
            sle_pkg::LD_INS: begin
                n_idx = w_nm1;
                n_rem = CW'(w_n - w_p + PW'(1));
            end
            sle_pkg::LD_POS: begin
                n_idx = w_pm1;
                n_rem = CW'(w_n - w_p);
            end
            sle_pkg::LD_SCAN: begin
                n_idx = '0;
                n_rem = r_cnt;
            end
            sle_pkg::LD_LAST: begin
                n_idx = w_nm1;
            end
            default: begin
                case (i_ctl.idx_op)
                    sle_pkg::IDX_INC: n_idx = r_idx + AW'(1);
                    sle_pkg::IDX_DEC: n_idx = r_idx - AW'(1);
                    default:          n_idx = r_idx;
                endcase
                if (i_ctl.rem_dec) begin
                    n_rem = r_rem - CW'(1);
                end
            end
        endcase

        case (i_ctl.cnt_op)
            sle_pkg::CNT_INC: n_cnt = r_cnt + CW'(1);
            sle_pkg::CNT_DEC: n_cnt = r_cnt - CW'(1);
            default:          n_cnt = r_cnt;
        endcase

        if (i_ctl.set_ok) begin
            n_ok = 1'b1;
        end
        if (i_ctl.min_elem) begin
            n_elem = r_min;
        end

        // read data handling in the cycle after the read
        case (r_fl_tag)
            sle_pkg::TG_FIND: begin
                if ((w_rd == r_val) && !r_ok) begin
                    n_ok = 1'b1;
                    n_at = 5'(w_at_full);
                end
            end
            sle_pkg::TG_MIN: begin
                if ((r_fl_addr == '0) || ($signed(w_rd) < $signed(r_min))) begin
                    n_min  = w_rd;
                    n_midx = r_fl_addr;
                end
            end
            sle_pkg::TG_ELEM: begin
                n_elem = w_rd;
            end
            default: begin
            end
        endcase

        // fresh beat clears the result fields
        if (i_accept) begin
            n_ok   = 1'b0;
            n_elem = '0;
            n_at   = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_fl_tag <= sle_pkg::TG_NONE;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_fl_tag <= i_ctl.rd_en ? i_ctl.tag : sle_pkg::TG_NONE;
            r_strobe <= i_ctl.done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_kind <= i_kind;
            r_pos  <= i_position;
            r_val  <= i_value;
        end
        r_idx     <= n_idx;
        r_rem     <= n_rem;
        r_ok      <= n_ok;
        r_elem    <= n_elem;
        r_at      <= n_at;
        r_min     <= n_min;
        r_midx    <= n_midx;
        r_fl_addr <= r_idx;
    end

    assign o_strobe   = r_strobe;
    assign o_ok       = r_ok;
    assign o_element  = r_elem;
    assign o_found_at = r_at;
    assign o_count    = 5'(r_cnt);

endmodule

// ===== sv/sle_seq.sv =====
module sle_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [2:0]     i_kind,
    input  sle_pkg::t_stat i_stat,
    output sle_pkg::t_ctrl o_ctl,
    output logic           o_busy
);

    sle_pkg::t_upc  r_upc,  n_upc;
    logic           r_busy, n_busy;
    sle_pkg::t_ctrl w_word;
    logic           w_cond;
    logic           w_act;

    // fetch and condition select
    always_comb begin
        w_word = sle_pkg::rom(r_upc);
        case (w_word.cond)
            sle_pkg::CND_BAD:   w_cond = i_stat.bad;
            sle_pkg::CND_REM_Z: w_cond = i_stat.rem_z;
            default:            w_cond = 1'b0;
        endcase
        // a looping word does nothing on the cycle it exits
        w_act = r_busy && !(w_word.hold && w_cond);
        o_ctl = w_act ? w_word : '0;
    end

    // step counter sequencing
    always_comb begin
        n_upc  = r_upc;
        n_busy = r_busy;
        if (!r_busy) begin
            if (i_accept) begin
                n_upc  = sle_pkg::entry(i_kind);
                n_busy = 1'b1;
            end
        end else begin
            if (w_cond) begin
                n_upc = w_word.target;
            end else if (!w_word.hold) begin
                n_upc = r_upc + sle_pkg::t_upc'(1);
            end
            if (w_act && w_word.done) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_upc  <= n_upc;
            r_busy <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== sv/sequential_list_engine_unit.sv =====
// Ordered list of up to CAPACITY signed 32-bit values with 1-based positions.
// Raise start with kind, position and value while busy is low; busy rises the
// next cycle. One result always follows, shown for exactly one cycle with
// strobe high, and must be taken then: there is no way to hold it off. A new
// start may be given in the strobe cycle. Operation time is set by the list
// store, a memory with one read port that the microcoded sequencer walks one
// entry a cycle for every shift, search and minimum scan, so find and
// delete-minimum grow with the count and insert and delete with count minus
// position. The store needs no clearing pass after reset; the count starts
// at zero.
module sequential_list_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_kind,
    input  logic [4:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               strobe,
    output logic               o_ok,
    output logic signed [31:0] o_element,
    output logic [4:0]         o_found_at,
    output logic [4:0]         o_count
);

    logic           w_accept;
    sle_pkg::t_ctrl w_ctl;
    sle_pkg::t_stat w_stat;

    // input beat taken when idle
    assign w_accept = start && !busy;

    sle_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_kind   (i_kind),
        .i_stat   (w_stat),
        .o_ctl    (w_ctl),
        .o_busy   (busy)
    );

    sle_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_kind     (i_kind),
        .i_position (i_position),
        .i_value    (i_value),
        .i_ctl      (w_ctl),
        .o_stat     (w_stat),
        .o_strobe   (strobe),
        .o_ok       (o_ok),
        .o_element  (o_element),
        .o_found_at (o_found_at),
        .o_count    (o_count)
    );

endmodule

// ===== sv/sle_chk.sv =====
module sle_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               strobe,
    input logic               o_ok,
    input logic signed [31:0] o_element,
    input logic [4:0]         o_found_at
);

    // an accepted beat always occupies the block
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // a result beat ends the operation
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |-> !busy)
        else $error("result beat while still busy");

    // busy only drops with a result
    a_fall_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> strobe)
        else $error("operation ended without a result beat");

    // failed operations carry no element
    a_fail_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && !o_ok) |-> (o_element == 32'sd0))
        else $error("failed operation returned an element");

    // a found position implies success
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && (o_found_at != 5'd0)) |-> o_ok)
        else $error("found position without success");

endmodule

bind sequential_list_engine_unit sle_chk u_chk (.*);
